FILE: src/awmh_pkg.sv
`default_nettype none

package awmh_pkg;

	localparam int TexelW        = 32;
	localparam int ChanW         = 8;
	localparam int NumTexels     = 4;
	localparam int NumChan       = 3;
	localparam int AlphaIdx      = 3;
	localparam int AsumW         = 10;
	localparam int ProdW         = 2 * ChanW;
	localparam int NumW          = 18;
	localparam int QuoW          = ChanW;
	localparam int StepsPerStage = 2;
	localparam int DivStages     = QuoW / StepsPerStage;
	localparam int AlphaRound    = 2;
	localparam int AlphaShift    = 2;

	typedef logic [ChanW-1:0] chan_t;
	typedef logic [NumTexels-1:0][TexelW-1:0] quad_t;

	// one texel in flight through the divider chain
	typedef struct packed {
		logic [NumChan-1:0][NumW-1:0] rem;
		logic [NumChan-1:0][QuoW-1:0] quo;
		logic [AsumW-1:0]             den;
		chan_t                        alpha;
	} awmh_div_t;

	function automatic chan_t chan_of(input logic [TexelW-1:0] texel, input int chan);
		return texel[chan*ChanW +: ChanW];
	endfunction

endpackage

`default_nettype wire

FILE: src/awmh_weight.sv
`default_nettype none

module awmh_weight (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              quad_valid,
	input  wire awmh_pkg::quad_t   texels,
	input  wire logic              hold_dn,
	output logic                   hold_up,
	output logic                   valid,
	output awmh_pkg::awmh_div_t    div
);
	import awmh_pkg::*;

	logic                 valid_s1;
	logic                 valid_s2;
	logic [ProdW-1:0]     prod_s1 [NumChan][NumTexels];
	logic [AsumW-1:0]     asum_s1;
	logic [ProdW-1:0]     prod_d [NumChan][NumTexels];
	logic [AsumW-1:0]     asum_d;
	logic                 hold_s1;
	logic                 hold_s2;
	logic [NumW-1:0]      num_d [NumChan];
	chan_t                alpha_d;
	awmh_div_t            div_d;
	awmh_div_t            div_s2;

	assign hold_s2 = valid_s2 && hold_dn;
	assign hold_s1 = valid_s1 && hold_s2;
	assign hold_up = hold_s1;

	// stage 1: alpha sum and colour * alpha products
	always_comb begin
		asum_d = '0;
		for (int i = 0; i < NumTexels; i++) begin
			asum_d = asum_d + AsumW'(chan_of(texels[i], AlphaIdx));
			for (int c = 0; c < NumChan; c++) begin
				prod_d[c][i] = ProdW'(chan_of(texels[i], c)) * ProdW'(chan_of(texels[i], AlphaIdx));
			end
		end
	end

	// stage 2: numerators with rounding bias, rounded alpha mean
	always_comb begin
		for (int c = 0; c < NumChan; c++) begin
			num_d[c] = NumW'(asum_s1 >> 1);
			for (int i = 0; i < NumTexels; i++) begin
				num_d[c] = num_d[c] + NumW'(prod_s1[c][i]);
			end
		end
		alpha_d = ChanW'((asum_s1 + AsumW'(AlphaRound)) >> AlphaShift);
		div_d = '0;
		for (int c = 0; c < NumChan; c++) begin
			div_d.rem[c] = num_d[c];
		end
		div_d.den   = asum_s1;
		div_d.alpha = alpha_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!hold_s1) valid_s1 <= quad_valid;
			if (!hold_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold_s1 && quad_valid) begin
			prod_s1 <= prod_d;
			asum_s1 <= asum_d;
		end
		if (!hold_s2 && valid_s1) begin
			div_s2 <= div_d;
		end
	end

	assign valid = valid_s2;
	assign div   = div_s2;

endmodule

`default_nettype wire

FILE: src/awmh_div_step.sv
`default_nettype none

module awmh_div_step #(
	parameter int StageIdx = 0
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 valid_in,
	input  wire awmh_pkg::awmh_div_t  div_in,
	input  wire logic                 hold_dn,
	output logic                      hold_up,
	output logic                      valid,
	output awmh_pkg::awmh_div_t       div
);
	import awmh_pkg::*;

	localparam int TopBit = QuoW - 1 - StageIdx * StepsPerStage;

	logic      valid_s;
	awmh_div_t div_s;
	awmh_div_t div_d;

	assign hold_up = valid_s && hold_dn;

	// two restoring steps, quotient bits shift in msb first
	always_comb begin
		logic [NumW-1:0] shifted;
		logic            ge;
		div_d = div_in;
		for (int s = 0; s < StepsPerStage; s++) begin
			shifted = NumW'(div_in.den) << (TopBit - s);
			for (int c = 0; c < NumChan; c++) begin
				ge = div_d.rem[c] >= shifted;
				if (ge) div_d.rem[c] = div_d.rem[c] - shifted;
				div_d.quo[c] = {div_d.quo[c][QuoW-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (!hold_up) begin
			valid_s <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold_up && valid_in) div_s <= div_d;
	end

	assign valid = valid_s;
	assign div   = div_s;

endmodule

`default_nettype wire

FILE: src/alpha_weighted_mip_halving.sv
`default_nettype none

// Pipeline: 2 weighting stages, then 4 divider stages, between quad transfer and mip_valid.
// Throughput: one quad per cycle while quad_stall is low; the divider retires 2 quotient bits per stage.
// Empty stages collapse, so quads are still taken while a result waits on mip_stall.
// Reset: arst_n asynchronously clears all stage valid bits; data registers are not reset.
module alpha_weighted_mip_halving (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          quad_valid,
	output logic                               quad_stall,
	input  wire logic [awmh_pkg::TexelW-1:0]   texel_top_left,
	input  wire logic [awmh_pkg::TexelW-1:0]   texel_top_right,
	input  wire logic [awmh_pkg::TexelW-1:0]   texel_bottom_left,
	input  wire logic [awmh_pkg::TexelW-1:0]   texel_bottom_right,
	output logic                               mip_valid,
	input  wire logic                          mip_stall,
	output logic [awmh_pkg::TexelW-1:0]        mip_texel
);
	import awmh_pkg::*;

	quad_t     texels;
	logic      v_c    [DivStages+1];
	logic      hold_c [DivStages+1];
	awmh_div_t div_c  [DivStages+1];
	awmh_div_t last;

	assign texels = {texel_bottom_right, texel_bottom_left, texel_top_right, texel_top_left};

	awmh_weight u_weight (
		.clk        (clk),
		.arst_n     (arst_n),
		.quad_valid (quad_valid),
		.texels     (texels),
		.hold_dn    (hold_c[0]),
		.hold_up    (quad_stall),
		.valid      (v_c[0]),
		.div        (div_c[0])
	);

	for (genvar g = 0; g < DivStages; g++) begin : g_div
		awmh_div_step #(.StageIdx(g)) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_in (v_c[g]),
			.div_in   (div_c[g]),
			.hold_dn  (hold_c[g+1]),
			.hold_up  (hold_c[g]),
			.valid    (v_c[g+1]),
			.div      (div_c[g+1])
		);
	end

	assign hold_c[DivStages] = mip_stall;
	assign last              = div_c[DivStages];
	assign mip_valid         = v_c[DivStages];

	// transparent quad gives all zeros
	always_comb begin
		mip_texel = '0;
		if (last.den != '0) begin
			for (int c = 0; c < NumChan; c++) begin
				mip_texel[c*ChanW +: ChanW] = last.quo[c];
			end
			mip_texel[AlphaIdx*ChanW +: ChanW] = last.alpha;
		end
	end

`ifndef SYNTHESIS
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		quad_stall |-> mip_valid && mip_stall)
		else $error("input stalled while output side is not blocked");

	a_alpha_den: assert property (@(posedge clk) disable iff (!arst_n)
		mip_valid && last.alpha != '0 |-> last.den != '0)
		else $error("nonzero alpha with zero alpha sum");

	a_rem_red: assert property (@(posedge clk) disable iff (!arst_n)
		mip_valid && last.den != '0 |->
		last.rem[0] < NumW'(last.den) && last.rem[1] < NumW'(last.den) &&
		last.rem[2] < NumW'(last.den))
		else $error("divider remainder not reduced");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_alpha_weighted_mip_halving.sv
`timescale 1ns / 1ps

module tb_alpha_weighted_mip_halving;

	import awmh_pkg::*;

	localparam int RandomQuads = 1250;
	localparam int DrainCycles = 40;
	localparam int DrainLimit  = 5000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                quad_valid = 1'b0;
	logic                quad_stall;
	logic [TexelW-1:0]   texel_top_left = '0;
	logic [TexelW-1:0]   texel_top_right = '0;
	logic [TexelW-1:0]   texel_bottom_left = '0;
	logic [TexelW-1:0]   texel_bottom_right = '0;
	logic                mip_valid;
	logic                mip_stall = 1'b0;
	logic [TexelW-1:0]   mip_texel;

	quad_t               pending_quads[$];
	logic [TexelW-1:0]   expected_mips[$];
	quad_t               next_quad;
	int                  total_quads = 1;
	int                  quads_offered = 0;
	int                  quads_taken = 0;
	int                  mips_checked = 0;
	int                  mismatch_count = 0;

	alpha_weighted_mip_halving uut (
		.clk                (clk),
		.arst_n             (arst_n),
		.quad_valid         (quad_valid),
		.quad_stall         (quad_stall),
		.texel_top_left     (texel_top_left),
		.texel_top_right    (texel_top_right),
		.texel_bottom_left  (texel_bottom_left),
		.texel_bottom_right (texel_bottom_right),
		.mip_valid          (mip_valid),
		.mip_stall          (mip_stall),
		.mip_texel          (mip_texel)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// alpha-weighted mean of the quad; alpha itself is the rounded plain mean
	function automatic logic [TexelW-1:0] halve_quad(input quad_t quad);
		int unsigned quad_asum;
		int unsigned weighted;
		int unsigned chan_val;
		int unsigned alpha_val;
		int unsigned mean;
		logic [TexelW-1:0] mip;
		quad_asum = 0;
		mip = '0;
		for (int i = 0; i < NumTexels; i++) begin
			alpha_val = quad[i][AlphaIdx*ChanW +: ChanW];
			quad_asum += alpha_val;
		end
		if (quad_asum != 0) begin
			for (int c = 0; c < NumChan; c++) begin
				weighted = 0;
				for (int i = 0; i < NumTexels; i++) begin
					chan_val = quad[i][c*ChanW +: ChanW];
					alpha_val = quad[i][AlphaIdx*ChanW +: ChanW];
					weighted += chan_val * alpha_val;
				end
				mean = (weighted + quad_asum / 2) / quad_asum;
				mip[c*ChanW +: ChanW] = mean[ChanW-1:0];
			end
			mean = (quad_asum + 2) / 4;
			mip[AlphaIdx*ChanW +: ChanW] = mean[ChanW-1:0];
		end
		return mip;
	endfunction

	function automatic logic [TexelW-1:0] random_texel(input int kind);
		logic [TexelW-1:0] colour;
		colour = $urandom & 32'h00FF_FFFF;
		case (kind)
			0: return $urandom;
			1: return colour;
			2: return colour | 32'hFF00_0000;
			default: return colour | ($urandom_range(3) << 24);
		endcase
	endfunction

	function automatic int send_idle_pct();
		case (quads_offered * 3 / total_quads)
			0: return 36;
			1: return 60;
			default: return 0;
		endcase
	endfunction

	function automatic int recv_stall_pct();
		case (quads_offered * 3 / total_quads)
			0: return 60;
			1: return 36;
			default: return 0;
		endcase
	endfunction

	task automatic add_quad(input logic [TexelW-1:0] tl, input logic [TexelW-1:0] tr,
			input logic [TexelW-1:0] bl, input logic [TexelW-1:0] br);
		pending_quads.insert(pending_quads.size(), {br, bl, tr, tl});
	endtask

	// driver: a new transfer is offered only once the previous one has been taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!quad_valid || quads_taken == quads_offered) begin
				if (pending_quads.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
					next_quad = pending_quads.pop_front();
					texel_top_left     <= next_quad[0];
					texel_top_right    <= next_quad[1];
					texel_bottom_left  <= next_quad[2];
					texel_bottom_right <= next_quad[3];
					quad_valid         <= 1'b1;
					quads_offered      = quads_offered + 1;
				end else begin
					quad_valid <= 1'b0;
				end
			end
			mip_stall <= ($urandom_range(99) < recv_stall_pct());
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (quad_valid && !quad_stall) begin
				expected_mips.insert(expected_mips.size(),
					halve_quad({texel_bottom_right, texel_bottom_left,
					texel_top_right, texel_top_left}));
				quads_taken = quads_taken + 1;
			end
			if (mip_valid && !mip_stall) begin
				if (expected_mips.size() == 0) begin
					$display("%0t: unexpected mip_texel transfer, actual %08h", $time, mip_texel);
					mismatch_count++;
				end else begin
					if (mip_texel !== expected_mips[0]) begin
						$display("%0t: mip_texel mismatch, expected %08h, actual %08h",
							$time, expected_mips[0], mip_texel);
						mismatch_count++;
					end
					void'(expected_mips.pop_front());
					mips_checked++;
				end
			end
		end
	end

	initial begin
		int pick;
		int drain;

		add_quad(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		add_quad(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_quad(32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF);
		add_quad(32'hFF00_0000, 32'hFF00_0000, 32'hFF00_0000, 32'hFF00_0000);
		add_quad(32'hFF12_3456, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF);
		add_quad(32'h00FF_FFFF, 32'hFFAB_CDEF, 32'h00FF_FFFF, 32'h00FF_FFFF);
		add_quad(32'h00FF_FFFF, 32'h00FF_FFFF, 32'hFF80_7F01, 32'h00FF_FFFF);
		add_quad(32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'hFFFE_0102);
		// alpha sum of one: alpha rounds to zero while colour survives
		add_quad(32'h01FF_80FF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		// alpha sum of two: alpha rounds up to one
		add_quad(32'h01FF_0000, 32'h0100_00FF, 32'h0000_0000, 32'h0000_0000);
		add_quad(32'h0100_0001, 32'h0100_0000, 32'h0000_0000, 32'h0000_0000);
		add_quad(32'h0100_0001, 32'h0100_0000, 32'h0100_0000, 32'h0000_0000);
		add_quad(32'h0300_0001, 32'h0100_0000, 32'h0000_0000, 32'h0000_0000);
		add_quad(32'hFFFF_FFFF, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000);
		add_quad(32'hFF00_0000, 32'h01FF_FFFF, 32'h01FF_FFFF, 32'h01FF_FFFF);
		add_quad(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
		add_quad(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
		add_quad(32'h80FF_FFFF, 32'h8000_0000, 32'h80FF_FFFF, 32'h8000_0000);
		add_quad(32'h7FFF_FFFF, 32'h7F00_0000, 32'h0000_0000, 32'h0000_0000);
		add_quad(32'h0201_0203, 32'h0202_0101, 32'h0000_0000, 32'h0000_0000);
		add_quad(32'hFE01_02FD, 32'h01FF_FEFF, 32'h40C0_4080, 32'hC040_C07F);
		for (int n = 0; n < RandomQuads; n++) begin
			pick = $urandom_range(99);
			if (pick < 10)
				add_quad(random_texel(1), random_texel(1), random_texel(1), random_texel(1));
			else if (pick < 20)
				add_quad(random_texel(3), random_texel(3), random_texel(3), random_texel(3));
			else if (pick < 30)
				add_quad(random_texel(2), random_texel(2), random_texel(2), random_texel(2));
			else if (pick < 45)
				add_quad(random_texel($urandom_range(3)), random_texel($urandom_range(3)),
					random_texel($urandom_range(3)), random_texel($urandom_range(3)));
			else
				add_quad(random_texel(0), random_texel(0), random_texel(0), random_texel(0));
		end
		total_quads = pending_quads.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_quads.size() > 0 || quad_valid) @(posedge clk);
		drain = 0;
		while (expected_mips.size() > 0 && drain < DrainLimit) begin
			@(posedge clk);
			drain++;
		end
		repeat (DrainCycles) @(posedge clk);
		if (expected_mips.size() > 0) begin
			$display("%0t: %0d mip_texel transfers never arrived", $time, expected_mips.size());
			mismatch_count++;
		end

		$display("Sent %0d quads (directed corners, transparent, low-alpha and random) under",
			quads_taken);
		$display("three throttling phases; %0d halved texels compared", mips_checked);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#200000;
		$display("Timed out waiting for transfers");
		$display("Mismatches found");
		$finish;
	end

endmodule
